/* rtl/biou_pkg.sv */
// Shared widths, types and the divider word for the box IoU block.
// No dependencies.
package biou_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRACTION_BITS = 16;
    localparam int AREA_BITS     = 2 * COORD_BITS;
    localparam int UNION_BITS    = AREA_BITS + 1;
    localparam int REM_BITS      = UNION_BITS + 1;
    localparam int RATIO_BITS    = FRACTION_BITS + 1;
    localparam int DIV_CELLS     = RATIO_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [AREA_BITS-1:0]  area_t;
    typedef logic [UNION_BITS-1:0] union_t;
    typedef logic [REM_BITS-1:0]   rem_t;
    typedef logic [RATIO_BITS-1:0] ratio_t;

    typedef struct packed {
        area_t  overlap_area;
        rem_t   rem;
        union_t den;
        ratio_t quo;
    } div_word_t;

endpackage

/* rtl/biou_if.sv */
// Request channels of the box IoU block: box pair in, result out.
// Depends on biou_pkg.
interface biou_box_if;
    import biou_pkg::*;

    logic   valid;
    logic   ready;
    coord_t a_left;
    coord_t a_bottom;
    coord_t a_right;
    coord_t a_top;
    coord_t b_left;
    coord_t b_bottom;
    coord_t b_right;
    coord_t b_top;

    modport source (output valid, a_left, a_bottom, a_right, a_top,
                    b_left, b_bottom, b_right, b_top, input ready);
    modport sink   (input valid, a_left, a_bottom, a_right, a_top,
                    b_left, b_bottom, b_right, b_top, output ready);
endinterface

interface biou_res_if;
    import biou_pkg::*;

    logic   valid;
    logic   ready;
    ratio_t overlap_ratio;
    area_t  overlap_area;
    union_t combined_area;
    logic   empty_union;

    modport source (output valid, overlap_ratio, overlap_area, combined_area,
                    empty_union, input ready);
    modport sink   (input valid, overlap_ratio, overlap_area, combined_area,
                    empty_union, output ready);
endinterface

/* rtl/biou_front.sv */
// Front end: extents, three area products and the union, three elastic stages.
// Depends on biou_pkg.
module biou_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  biou_pkg::coord_t    a_left,
    input  biou_pkg::coord_t    a_bottom,
    input  biou_pkg::coord_t    a_right,
    input  biou_pkg::coord_t    a_top,
    input  biou_pkg::coord_t    b_left,
    input  biou_pkg::coord_t    b_bottom,
    input  biou_pkg::coord_t    b_right,
    input  biou_pkg::coord_t    b_top,
    output logic                out_valid,
    input  logic                out_ready,
    output biou_pkg::div_word_t out_word
);
    import biou_pkg::*;

    logic   v1_reg, v2_reg, v3_reg;
    logic   rdy1, rdy2, rdy3;

    coord_t w_a_reg, h_a_reg, w_b_reg, h_b_reg, ix_reg, iy_reg;
    coord_t w_a_next, h_a_next, w_b_next, h_b_next, ix_next, iy_next;
    coord_t x_lo, x_hi, y_lo, y_hi;

    area_t  area_a_reg, area_b_reg, inter_reg;
    area_t  area_a_next, area_b_next, inter_next;

    area_t  ovl_reg;
    union_t uni_reg, uni_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        x_lo     = (a_left > b_left) ? a_left : b_left;
        x_hi     = (a_right < b_right) ? a_right : b_right;
        y_lo     = (a_bottom > b_bottom) ? a_bottom : b_bottom;
        y_hi     = (a_top < b_top) ? a_top : b_top;
        w_a_next = (a_right > a_left) ? a_right - a_left : '0;
        h_a_next = (a_top > a_bottom) ? a_top - a_bottom : '0;
        w_b_next = (b_right > b_left) ? b_right - b_left : '0;
        h_b_next = (b_top > b_bottom) ? b_top - b_bottom : '0;
        ix_next  = (x_hi > x_lo) ? x_hi - x_lo : '0;
        iy_next  = (y_hi > y_lo) ? y_hi - y_lo : '0;
    end

    assign area_a_next = AREA_BITS'(w_a_reg) * AREA_BITS'(h_a_reg);
    assign area_b_next = AREA_BITS'(w_b_reg) * AREA_BITS'(h_b_reg);
    assign inter_next  = AREA_BITS'(ix_reg) * AREA_BITS'(iy_reg);

    // intersection never exceeds either area, so no underflow
    assign uni_next = UNION_BITS'(area_a_reg) + UNION_BITS'(area_b_reg)
                    - UNION_BITS'(inter_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            w_a_reg <= w_a_next;
            h_a_reg <= h_a_next;
            w_b_reg <= w_b_next;
            h_b_reg <= h_b_next;
            ix_reg  <= ix_next;
            iy_reg  <= iy_next;
        end
        if (rdy2 && v1_reg)
        begin
            area_a_reg <= area_a_next;
            area_b_reg <= area_b_next;
            inter_reg  <= inter_next;
        end
        if (rdy3 && v2_reg)
        begin
            ovl_reg <= inter_reg;
            uni_reg <= uni_next;
        end
    end

    assign out_valid             = v3_reg;
    assign out_word.overlap_area = ovl_reg;
    assign out_word.rem          = REM_BITS'(ovl_reg);
    assign out_word.den          = uni_reg;
    assign out_word.quo          = '0;

endmodule

/* rtl/biou_div_cell.sv */
// One restoring-division cell: one quotient bit per cell, elastic handoff.
// Depends on biou_pkg.
module biou_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  biou_pkg::div_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output biou_pkg::div_word_t out_word
);
    import biou_pkg::*;

    logic      valid_reg;
    div_word_t word_reg, word_next;
    logic      take;
    rem_t      diff, rem_sel;

    always_comb
    begin
        take    = in_word.rem >= REM_BITS'(in_word.den);
        diff    = in_word.rem - REM_BITS'(in_word.den);
        rem_sel = take ? diff : in_word.rem;
        word_next              = in_word;
        word_next.rem          = {rem_sel[REM_BITS-2:0], 1'b0};
        word_next.quo          = {in_word.quo[RATIO_BITS-2:0], take};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* rtl/box_intersection_over_union.sv */
// Top level of the box IoU block: front end followed by a chain of divider cells.
// Depends on biou_pkg, biou_if, biou_front, biou_div_cell.
//
//  channel | modport | carries
//  boxes   | sink    | a_left a_bottom a_right a_top b_left b_bottom b_right b_top
//  iou     | source  | overlap_ratio overlap_area combined_area empty_union
//
// One request per cycle in, one result per cycle out, while the output is not stalled.
// The pipeline is three front stages followed by one divider cell per quotient bit.
// Every stage has its own valid bit and takes data whenever it is empty or its
// successor moves, so bubbles collapse and a stalled output does not block input
// until the whole chain is full. Reset clears all valid bits; no other setup.
module box_intersection_over_union (
    input  logic clk,
    input  logic rst_n,
    biou_box_if.sink   boxes,
    biou_res_if.source iou
);
    import biou_pkg::*;

    logic      vld   [DIV_CELLS+1];
    logic      rdy   [DIV_CELLS+1];
    div_word_t word  [DIV_CELLS+1];
    div_word_t last;
    logic      empty;

    biou_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (boxes.valid),
        .in_ready  (boxes.ready),
        .a_left    (boxes.a_left),
        .a_bottom  (boxes.a_bottom),
        .a_right   (boxes.a_right),
        .a_top     (boxes.a_top),
        .b_left    (boxes.b_left),
        .b_bottom  (boxes.b_bottom),
        .b_right   (boxes.b_right),
        .b_top     (boxes.b_top),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_word  (word[0])
    );

    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_cell
        biou_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .in_word   (word[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .out_word  (word[i+1])
        );
    end

    assign last             = word[DIV_CELLS];
    assign empty            = (last.den == '0);
    assign rdy[DIV_CELLS]   = iou.ready;
    assign iou.valid        = vld[DIV_CELLS];
    assign iou.overlap_ratio = empty ? '0 : last.quo;
    assign iou.overlap_area  = last.overlap_area;
    assign iou.combined_area = last.den;
    assign iou.empty_union   = empty;

    a_empty_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        iou.valid && iou.empty_union |-> iou.overlap_ratio == '0)
        else $error("nonzero ratio with empty union");

    a_inter_le_union: assert property (@(posedge clk) disable iff (!rst_n)
        iou.valid |-> UNION_BITS'(iou.overlap_area) <= iou.combined_area)
        else $error("intersection larger than union");

    a_full_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        iou.valid && iou.overlap_ratio[FRACTION_BITS]
            |-> UNION_BITS'(iou.overlap_area) == iou.combined_area)
        else $error("ratio of one without full overlap");

    a_ratio_cap: assert property (@(posedge clk) disable iff (!rst_n)
        iou.valid && iou.overlap_ratio[FRACTION_BITS]
            |-> iou.overlap_ratio[FRACTION_BITS-1:0] == '0)
        else $error("ratio above one");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for box_intersection_over_union: box pairs in, IoU results out.
// Depends on biou_pkg, biou_box_if, biou_res_if and the block itself.
`timescale 1ns / 1ps

module tb_top;
    import biou_pkg::*;

    localparam int LATENCY      = 3 + FRACTION_BITS + 1;
    localparam int RANDOM_PAIRS = 1950;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        coord_t a_left;
        coord_t a_bottom;
        coord_t a_right;
        coord_t a_top;
        coord_t b_left;
        coord_t b_bottom;
        coord_t b_right;
        coord_t b_top;
    } box_pair_t;

    typedef struct {
        ratio_t overlap_ratio;
        area_t  overlap_area;
        union_t combined_area;
        logic   empty_union;
    } iou_result_t;

    class iou_scoreboard;
        iou_result_t expected_iou[$];
        int failures;
        int mismatches;

        function new();
            failures   = 0;
            mismatches = 0;
        endfunction

        function longint unsigned extent(coord_t lo, coord_t hi);
            return (hi > lo) ? longint'(hi) - longint'(lo) : 0;
        endfunction

        function iou_result_t predict_iou(box_pair_t p);
            iou_result_t     r;
            longint unsigned area_a;
            longint unsigned area_b;
            longint unsigned inter;
            longint unsigned uni;
            longint unsigned quo;
            coord_t          lo_x;
            coord_t          hi_x;
            coord_t          lo_y;
            coord_t          hi_y;
            area_a = extent(p.a_left, p.a_right) * extent(p.a_bottom, p.a_top);
            area_b = extent(p.b_left, p.b_right) * extent(p.b_bottom, p.b_top);
            lo_x   = (p.a_left > p.b_left) ? p.a_left : p.b_left;
            hi_x   = (p.a_right < p.b_right) ? p.a_right : p.b_right;
            lo_y   = (p.a_bottom > p.b_bottom) ? p.a_bottom : p.b_bottom;
            hi_y   = (p.a_top < p.b_top) ? p.a_top : p.b_top;
            inter  = extent(lo_x, hi_x) * extent(lo_y, hi_y);
            uni    = area_a + area_b - inter;
            quo    = 0;
            if (uni != 0)
            begin
                quo = (inter << FRACTION_BITS) / uni;
            end
            r.overlap_ratio = quo[RATIO_BITS-1:0];
            r.overlap_area  = inter[AREA_BITS-1:0];
            r.combined_area = uni[UNION_BITS-1:0];
            r.empty_union   = (uni == 0);
            return r;
        endfunction

        function void note_pair(box_pair_t p);
            expected_iou.push_back(predict_iou(p));
        endfunction

        function int outstanding();
            return expected_iou.size();
        endfunction

        function void check_result(iou_result_t got);
            iou_result_t want;
            if (expected_iou.size() == 0)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: ratio %0d area %0d union %0d empty %0b",
                             got.overlap_ratio, got.overlap_area, got.combined_area,
                             got.empty_union);
                end
                return;
            end
            want = expected_iou.pop_front();
            if (got.overlap_ratio !== want.overlap_ratio ||
                got.overlap_area  !== want.overlap_area  ||
                got.combined_area !== want.combined_area ||
                got.empty_union   !== want.empty_union)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: exp ratio %0d area %0d union %0d empty %0b",
                             want.overlap_ratio, want.overlap_area, want.combined_area,
                             want.empty_union);
                    $display("          got ratio %0d area %0d union %0d empty %0b",
                             got.overlap_ratio, got.overlap_area, got.combined_area,
                             got.empty_union);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic hold_go;
    int   sink_idle_pct;
    int   source_idle_pct;
    int   cycles;

    iou_scoreboard sb;

    biou_box_if boxes_ch ();
    biou_res_if iou_ch ();

    box_intersection_over_union DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .boxes (boxes_ch.sink),
        .iou   (iou_ch.source)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        box_pair_t   p;
        iou_result_t r;
        if (rst_n && boxes_ch.valid && boxes_ch.ready)
        begin
            p.a_left   = boxes_ch.a_left;
            p.a_bottom = boxes_ch.a_bottom;
            p.a_right  = boxes_ch.a_right;
            p.a_top    = boxes_ch.a_top;
            p.b_left   = boxes_ch.b_left;
            p.b_bottom = boxes_ch.b_bottom;
            p.b_right  = boxes_ch.b_right;
            p.b_top    = boxes_ch.b_top;
            sb.note_pair(p);
        end
        if (rst_n && iou_ch.valid && iou_ch.ready)
        begin
            r.overlap_ratio = iou_ch.overlap_ratio;
            r.overlap_area  = iou_ch.overlap_area;
            r.combined_area = iou_ch.combined_area;
            r.empty_union   = iou_ch.empty_union;
            sb.check_result(r);
        end
    end

    // result sink: random back-pressure plus one long hold-off
    initial
    begin : result_sink
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 0;
        iou_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_taken)
            begin
                hold_taken = 1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                iou_ch.ready <= 1'b0;
            end
            else
            begin
                iou_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic send_pair(input box_pair_t p);
        boxes_ch.valid    <= 1'b1;
        boxes_ch.a_left   <= p.a_left;
        boxes_ch.a_bottom <= p.a_bottom;
        boxes_ch.a_right  <= p.a_right;
        boxes_ch.a_top    <= p.a_top;
        boxes_ch.b_left   <= p.b_left;
        boxes_ch.b_bottom <= p.b_bottom;
        boxes_ch.b_right  <= p.b_right;
        boxes_ch.b_top    <= p.b_top;
        do
            @(posedge clk);
        while (!boxes_ch.ready);
    endtask

    task automatic source_gaps();
        while ($urandom_range(99) < source_idle_pct)
        begin
            boxes_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        boxes_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    function automatic box_pair_t make_pair(int al, int ab, int ar, int at,
                                            int bl, int bb, int br, int bt);
        box_pair_t p;
        p.a_left   = coord_t'(al);
        p.a_bottom = coord_t'(ab);
        p.a_right  = coord_t'(ar);
        p.a_top    = coord_t'(at);
        p.b_left   = coord_t'(bl);
        p.b_bottom = coord_t'(bb);
        p.b_right  = coord_t'(br);
        p.b_top    = coord_t'(bt);
        return p;
    endfunction

    function automatic box_pair_t random_pair();
        box_pair_t p;
        p.a_left   = coord_t'($urandom);
        p.a_bottom = coord_t'($urandom);
        p.a_right  = coord_t'($urandom);
        p.a_top    = coord_t'($urandom);
        p.b_left   = coord_t'($urandom);
        p.b_bottom = coord_t'($urandom);
        p.b_right  = coord_t'($urandom);
        p.b_top    = coord_t'($urandom);
        case ($urandom_range(9))
            0, 1:
            begin
            end
            2, 3, 4:
            begin
                // dense small grid: overlaps, touching edges, containment
                p.a_left   = coord_t'($urandom_range(63));
                p.a_bottom = coord_t'($urandom_range(63));
                p.a_right  = coord_t'(p.a_left + $urandom_range(40));
                p.a_top    = coord_t'(p.a_bottom + $urandom_range(40));
                p.b_left   = coord_t'($urandom_range(63));
                p.b_bottom = coord_t'($urandom_range(63));
                p.b_right  = coord_t'(p.b_left + $urandom_range(40));
                p.b_top    = coord_t'(p.b_bottom + $urandom_range(40));
            end
            5, 6, 7:
            begin
                p.a_left   = coord_t'($urandom_range(60000));
                p.a_bottom = coord_t'($urandom_range(60000));
                p.a_right  = coord_t'(p.a_left + $urandom_range(5535));
                p.a_top    = coord_t'(p.a_bottom + $urandom_range(5535));
                p.b_left   = coord_t'(p.a_left + $urandom_range(4000));
                p.b_bottom = coord_t'(p.a_bottom + $urandom_range(4000));
                p.b_right  = coord_t'(p.b_left + $urandom_range(5535));
                p.b_top    = coord_t'(p.b_bottom + $urandom_range(5535));
            end
            8:
            begin
                // near-maximal boxes
                p.a_left   = coord_t'($urandom_range(3));
                p.a_bottom = coord_t'($urandom_range(3));
                p.a_right  = coord_t'(16'hFFFF - $urandom_range(3));
                p.a_top    = coord_t'(16'hFFFF - $urandom_range(3));
                p.b_left   = coord_t'($urandom_range(3));
                p.b_bottom = coord_t'($urandom_range(3));
                p.b_right  = coord_t'(16'hFFFF - $urandom_range(3));
                p.b_top    = coord_t'(16'hFFFF - $urandom_range(3));
            end
            default:
            begin
                p.b_left   = coord_t'(p.a_left + $urandom_range(1));
                p.b_bottom = p.a_bottom;
                p.b_right  = coord_t'(p.a_right + $urandom_range(1));
                p.b_top    = p.a_top;
            end
        endcase
        return p;
    endfunction

    initial
    begin : stimulus
        box_pair_t directed[$];
        sb = new();
        rst_n             <= 1'b0;
        hold_go           <= 1'b0;
        sink_idle_pct     <= 0;
        source_idle_pct    = 0;
        boxes_ch.valid    <= 1'b0;
        boxes_ch.a_left   <= '0;
        boxes_ch.a_bottom <= '0;
        boxes_ch.a_right  <= '0;
        boxes_ch.a_top    <= '0;
        boxes_ch.b_left   <= '0;
        boxes_ch.b_bottom <= '0;
        boxes_ch.b_right  <= '0;
        boxes_ch.b_top    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_pair(0, 0, 65535, 65535, 0, 0, 65535, 65535));
        directed.push_back(make_pair(0, 0, 65535, 65535, 900, 10, 100, 500));
        directed.push_back(make_pair(50, 0, 10, 20, 0, 40, 20, 5));
        directed.push_back(make_pair(0, 0, 10, 10, 10, 0, 20, 10));
        directed.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 20));
        directed.push_back(make_pair(0, 0, 10, 10, 100, 100, 200, 200));
        directed.push_back(make_pair(0, 0, 100, 100, 20, 30, 40, 70));
        directed.push_back(make_pair(0, 0, 100, 100, 50, 50, 150, 150));
        directed.push_back(make_pair(5, 0, 5, 100, 0, 0, 10, 10));
        directed.push_back(make_pair(65535, 65535, 65535, 65535, 65535, 65535,
                                     65535, 65535));
        directed.push_back(make_pair(0, 90, 100, 10, 0, 0, 100, 100));
        directed.push_back(make_pair(7, 7, 8, 8, 7, 7, 8, 8));
        directed.push_back(make_pair(0, 0, 10, 100, 5, 50, 20, 200));
        directed.push_back(make_pair(16'hAAAA, 16'h5555, 16'hFFFF, 16'hAAAA,
                                     16'h5555, 16'h0000, 16'hAAAA, 16'hFFFF));
        directed.push_back(make_pair(0, 0, 65535, 65535, 0, 0, 1, 1));
        directed.push_back(make_pair(0, 0, 65535, 1, 0, 0, 1, 65535));
        directed.push_back(make_pair(65534, 0, 65535, 65535, 0, 0, 65535, 65535));
        foreach (directed[i])
        begin
            send_pair(directed[i]);
        end
        drain_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    source_idle_pct  = 8;
                    sink_idle_pct   <= 88;
                end
                1:
                begin
                    source_idle_pct  = 88;
                    sink_idle_pct   <= 8;
                end
                default:
                begin
                    source_idle_pct  = 0;
                    sink_idle_pct   <= 0;
                    hold_go         <= 1'b1;
                end
            endcase
            for (int n = 0; n < RANDOM_PAIRS / 3; n++)
            begin
                source_gaps();
                send_pair(random_pair());
            end
            drain_results();
        end

        repeat (2 * LATENCY) @(posedge clk);
        if (sb.failures == 0 && sb.outstanding() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
